// ===== rtl/sts_pkg.sv =====
// Package for the sorted table search block: table geometry, codes and payload types.
// Used by sorted_table_search; the RAM module takes its sizes as parameters instead.
package sts_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int DATA_W      = 32;
	// Signed range bound: holds -1 up to TABLE_DEPTH.
	localparam int PTR_W       = ADDR_W + 2;
	// Product of a key offset and a range span.
	localparam int PROD_W      = DATA_W + ADDR_W;
	localparam int DIVCNT_W    = $clog2(ADDR_W);

	// Configuration port.
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = COUNT_W;

	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

	// Item function codes.
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Search mode codes.
	localparam logic MODE_BINARY = 1'b0;
	localparam logic MODE_INTERP = 1'b1;

	typedef struct packed {
		logic                     func;
		logic [ADDR_W-1:0]        entry_index;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [DATA_W-1:0] search_key;
	} item_t;

	typedef struct packed {
		logic               found;
		logic [ADDR_W-1:0]  position;
		logic [COUNT_W-1:0] probe_count;
	} result_t;

endpackage

// ===== rtl/sts_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; depends on nothing else.
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/sorted_table_search.sv =====
// Write item: written to the table as it is taken. Search item: a binary-mode probe steps
// through CHECK, PROBE and WAIT_MID; an interpolation-mode probe also passes RD_LO, RD_HI, MUL,
// DIV and MID_SET (three table reads through the single read port plus a one-bit-per-cycle divider).
// One item is worked on at a time; a finished result may wait in the output register.
// Reset clears control state, search_mode and entry_count; the table is not cleared
// and holds whatever was written. Depends on sts_pkg and sts_ram.
module sorted_table_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  sts_pkg::item_t               item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output sts_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sts_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_CHECK    = 10'b0000000010,
		ST_RD_LO    = 10'b0000000100,
		ST_RD_HI    = 10'b0000001000,
		ST_MUL      = 10'b0000010000,
		ST_DIV      = 10'b0000100000,
		ST_MID_SET  = 10'b0001000000,
		ST_PROBE    = 10'b0010000000,
		ST_WAIT_MID = 10'b0100000000,
		ST_FINISH   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic                                 mode_q;
	logic [sts_pkg::COUNT_W-1:0]          count_q;
	logic signed [sts_pkg::DATA_W-1:0]    key_q;
	logic signed [sts_pkg::PTR_W-1:0]     left_q;
	logic signed [sts_pkg::PTR_W-1:0]     right_q;
	logic [sts_pkg::ADDR_W-1:0]           mid_q;
	logic [sts_pkg::COUNT_W-1:0]          probes_q;
	logic                                 hit_q;
	logic [sts_pkg::ADDR_W-1:0]           pos_q;
	logic signed [sts_pkg::DATA_W-1:0]    lo_q;
	logic [sts_pkg::DATA_W-1:0]           diff_q;
	logic [sts_pkg::DATA_W-1:0]           den_q;
	logic [sts_pkg::ADDR_W-1:0]           span_q;
	logic [sts_pkg::DATA_W-1:0]           rem_q;
	logic [sts_pkg::ADDR_W-1:0]           quo_q;
	logic [sts_pkg::DIVCNT_W-1:0]         div_cnt_q;
	logic                                 result_valid_q;
	sts_pkg::result_t                     result_q;

	logic                                 item_take;
	logic                                 out_free;
	logic [sts_pkg::COUNT_W-1:0]          n_sat;
	logic signed [sts_pkg::PTR_W-1:0]     range_span;
	logic signed [sts_pkg::PTR_W-1:0]     mid_bin;
	logic signed [sts_pkg::DATA_W-1:0]    rd_value;
	logic signed [sts_pkg::DATA_W:0]      key_minus_lo;
	logic signed [sts_pkg::DATA_W:0]      hi_minus_lo;
	logic [sts_pkg::PROD_W-1:0]           prod;
	logic [sts_pkg::DATA_W:0]             trial;
	logic                                 trial_ge;
	logic [sts_pkg::DATA_W:0]             trial_sub;
	logic signed [sts_pkg::PTR_W-1:0]     mid_ext;
	logic signed [sts_pkg::PTR_W-1:0]     mid_interp;
	logic [sts_pkg::ADDR_W-1:0]           ram_rd_addr;
	logic [sts_pkg::DATA_W-1:0]           ram_rd_data;
	logic                                 ram_wr_en;

	// Handshakes: items enter only between searches; configuration is always taken.
	assign item_stall   = (state_q != ST_IDLE);
	assign item_take    = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Entry count above the table depth saturates.
	assign n_sat = (count_q > sts_pkg::COUNT_W'(sts_pkg::TABLE_DEPTH)) ?
		sts_pkg::COUNT_W'(sts_pkg::TABLE_DEPTH) : count_q;

	// Binary midpoint of the current range.
	assign range_span = right_q - left_q;
	assign mid_bin    = left_q + (range_span >>> 1);

	// Range endpoint arithmetic for interpolation.
	assign rd_value     = $signed(ram_rd_data);
	assign key_minus_lo = {key_q[sts_pkg::DATA_W-1], key_q} - {lo_q[sts_pkg::DATA_W-1], lo_q};
	assign hi_minus_lo  = {rd_value[sts_pkg::DATA_W-1], rd_value}
		- {lo_q[sts_pkg::DATA_W-1], lo_q};
	assign prod = sts_pkg::PROD_W'(diff_q) * sts_pkg::PROD_W'(span_q);

	// One quotient bit per cycle of the restoring divider.
	assign trial     = {rem_q, quo_q[sts_pkg::ADDR_W-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	assign mid_ext    = $signed({2'b00, mid_q});
	assign mid_interp = left_q + $signed({2'b00, quo_q});

	// Read address follows the state: left end, right end, or probe point.
	always_comb begin
		case (state_q)
			ST_CHECK: ram_rd_addr = left_q[sts_pkg::ADDR_W-1:0];
			ST_RD_LO: ram_rd_addr = right_q[sts_pkg::ADDR_W-1:0];
			default:  ram_rd_addr = mid_q;
		endcase
	end

	assign ram_wr_en = item_take && (item.func == sts_pkg::FUNC_WRITE);

	sts_ram #(
		.WIDTH(sts_pkg::DATA_W),
		.DEPTH(sts_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (item.entry_index),
		.wr_data (item.entry_value),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sts_pkg::MODE_BINARY;
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sts_pkg::REG_SEARCH_MODE: mode_q  <= cfg_data[0];
				sts_pkg::REG_ENTRY_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Search sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_take && item.func == sts_pkg::FUNC_SEARCH) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (left_q > right_q) begin
						state_q <= ST_FINISH;
					end else if (mode_q == sts_pkg::MODE_BINARY) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_RD_LO;
					end
				end
				ST_RD_LO: state_q <= ST_RD_HI;
				ST_RD_HI: begin
					if (key_q < lo_q || key_q > rd_value) begin
						state_q <= ST_FINISH;
					end else if (rd_value == lo_q) begin
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_cnt_q == sts_pkg::DIVCNT_W'(sts_pkg::ADDR_W - 1)) begin
						state_q <= ST_MID_SET;
					end
				end
				ST_MID_SET: state_q <= ST_PROBE;
				ST_PROBE:   state_q <= ST_WAIT_MID;
				ST_WAIT_MID: begin
					if (rd_value == key_q) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q    <= item.search_key;
				left_q   <= '0;
				right_q  <= $signed({1'b0, n_sat}) - sts_pkg::PTR_W'(1);
				probes_q <= '0;
				hit_q    <= 1'b0;
				pos_q    <= '0;
			end
			ST_CHECK: begin
				mid_q <= mid_bin[sts_pkg::ADDR_W-1:0];
			end
			ST_RD_LO: begin
				lo_q <= rd_value;
			end
			ST_RD_HI: begin
				mid_q  <= left_q[sts_pkg::ADDR_W-1:0];
				diff_q <= key_minus_lo[sts_pkg::DATA_W-1:0];
				den_q  <= hi_minus_lo[sts_pkg::DATA_W-1:0];
				span_q <= range_span[sts_pkg::ADDR_W-1:0];
			end
			ST_MUL: begin
				rem_q     <= prod[sts_pkg::PROD_W-1:sts_pkg::ADDR_W];
				quo_q     <= prod[sts_pkg::ADDR_W-1:0];
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= trial_ge ? trial_sub[sts_pkg::DATA_W-1:0] :
					trial[sts_pkg::DATA_W-1:0];
				quo_q     <= {quo_q[sts_pkg::ADDR_W-2:0], trial_ge};
				div_cnt_q <= div_cnt_q + sts_pkg::DIVCNT_W'(1);
			end
			ST_MID_SET: begin
				mid_q <= mid_interp[sts_pkg::ADDR_W-1:0];
			end
			ST_PROBE: begin
				probes_q <= probes_q + sts_pkg::COUNT_W'(1);
			end
			ST_WAIT_MID: begin
				if (rd_value == key_q) begin
					hit_q <= 1'b1;
					pos_q <= mid_q;
				end else if (rd_value < key_q) begin
					left_q <= mid_ext + sts_pkg::PTR_W'(1);
				end else begin
					right_q <= mid_ext - sts_pkg::PTR_W'(1);
				end
			end
			default: ;
		endcase
	end

	// Output register: loaded when a search ends and the previous transfer is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			result_q.found       <= hit_q;
			result_q.position    <= pos_q;
			result_q.probe_count <= probes_q;
		end
	end

`ifndef NO_ASSERTIONS
	// A new result only appears as a search finishes.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result appeared without a finished search");

	// A hit always took at least one probe.
	a_hit_has_probe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.found |-> result_q.probe_count != '0)
		else $error("hit reported with zero probes");

	// A miss reports position zero.
	a_miss_position: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.found |-> result_q.position == '0)
		else $error("miss reported a nonzero position");

	// The interpolation quotient never leaves the current range.
	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MID_SET |-> quo_q <= span_q)
		else $error("interpolation probe outside range");
`endif

endmodule

// ===== tb/tb_sorted_table_search.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_search: table loads, binary and interpolation
// searches under random bursts and output stalls, checked against an in-bench predictor.
// Depends on sts_pkg and the sorted_table_search RTL.
module tb_sorted_table_search;
	import sts_pkg::*;

	localparam int     TIMEOUT_NS   = 200_000_000;
	localparam int     RANDOM_ITEMS = 900;
	localparam int     SETTLE_CYCLES = 20;
	localparam longint VALUE_MIN    = -64'sd2147483648;
	localparam longint VALUE_MAX    = 64'sd2147483647;

	typedef enum int {TABLE_SPREAD, TABLE_CLUSTERED, TABLE_FLAT, TABLE_SHUFFLED} table_kind_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	item_t                  item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	// Items waiting to be driven, and search results still owed by the block.
	item_t   pending_items[$];
	result_t expected_results[$];
	int      error_count = 0;

	// Predictor copy of the table and the registers, updated on accepted transfers.
	logic signed [DATA_W-1:0] table_model [0:TABLE_DEPTH-1];
	logic                     mode_model  = MODE_BINARY;
	logic [COUNT_W-1:0]       count_model = '0;

	// Stimulus-side copy of the table, used to pick keys that hit.
	longint gen_table [0:TABLE_DEPTH-1];

	// Driver and receiver pacing state.
	logic         item_fired = 1'b0;
	int           burst_left = 0;
	int           gap_left   = 0;
	bit           drain_wait = 1'b0;
	stall_style_t stall_style = STALL_NONE;
	int           stall_span  = 0;

	sorted_table_search u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Searches the predictor table for a key with the current mode and entry count.
	function automatic result_t search_table(input logic signed [DATA_W-1:0] key);
		longint  k, lft, rgt, mid, lo_v, hi_v, v, n;
		result_t r;
		r = '0;
		k = key;
		n = (count_model > TABLE_DEPTH) ? TABLE_DEPTH : count_model;
		lft = 0;
		rgt = n - 1;
		while (lft <= rgt) begin
			if (mode_model == MODE_BINARY) begin
				mid = lft + (rgt - lft) / 2;
			end else begin
				lo_v = table_model[lft];
				hi_v = table_model[rgt];
				// Interpolation gives up once the key lies outside the end values.
				if (k < lo_v || k > hi_v)
					break;
				if (hi_v == lo_v)
					mid = lft;
				else
					mid = lft + ((k - lo_v) * (rgt - lft)) / (hi_v - lo_v);
			end
			r.probe_count = r.probe_count + 1'b1;
			v = table_model[mid];
			if (v == k) begin
				r.found    = 1'b1;
				r.position = mid[ADDR_W-1:0];
				break;
			end
			if (v < k)
				lft = mid + 1;
			else
				rgt = mid - 1;
		end
		return r;
	endfunction

	// Prediction on every accepted item and register write.
	always @(posedge clk) begin
		item_fired = arst_n && item_valid && !item_stall;
		if (item_fired) begin
			if (item.func == FUNC_WRITE)
				table_model[item.entry_index] = item.entry_value;
			else
				expected_results.push_back(search_table(item.search_key));
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEARCH_MODE: mode_model = cfg_data[0];
				REG_ENTRY_COUNT: count_model = cfg_data;
				default: ;
			endcase
		end
	end

	// Result checking against the oldest expectation.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no search outstanding: found %0d position %0d probes %0d",
					result.found, result.position, result.probe_count);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.found !== want.found) begin
					$error("found mismatch: expected %0d, got %0d", want.found, result.found);
					error_count++;
				end
				if (result.position !== want.position) begin
					$error("position mismatch: expected %0d, got %0d",
						want.position, result.position);
					error_count++;
				end
				if (result.probe_count !== want.probe_count) begin
					$error("probe_count mismatch: expected %0d, got %0d",
						want.probe_count, result.probe_count);
					error_count++;
				end
			end
		end
	end

	// Item driver: bursts of random length with random gaps, and an occasional drain.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && !item_fired) begin
			// Stalled transfer: hold the payload.
		end else if (gap_left > 0) begin
			gap_left--;
			item_valid <= 1'b0;
		end else if (drain_wait && expected_results.size() != 0) begin
			item_valid <= 1'b0;
		end else if (pending_items.size() != 0) begin
			item       <= pending_items.pop_front();
			item_valid <= 1'b1;
			drain_wait = ($urandom_range(0, 99) == 0);
			burst_left--;
			if (burst_left <= 0) begin
				if ($urandom_range(0, 3) == 0) begin
					burst_left = $urandom_range(50, 200);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left   = $urandom_range(1, 8);
				end
			end
		end else begin
			item_valid <= 1'b0;
		end
	end

	// Result receiver: stall behavior switches to a random style after each random span.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (stall_span == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				stall_span  = $urandom_range(20, 300);
			end else begin
				stall_span--;
			end
			case (stall_style)
				STALL_NONE:     result_stall <= 1'b0;
				STALL_LIGHT:    result_stall <= ($urandom_range(0, 2) == 0);
				STALL_HEAVY:    result_stall <= ($urandom_range(0, 9) != 0);
				STALL_PERIODIC: result_stall <= stall_span[2];
				default:        result_stall <= 1'b0;
			endcase
		end
	end

	task automatic push_write(input int idx, input longint val);
		item_t it;
		it.func        = FUNC_WRITE;
		it.entry_index = idx[ADDR_W-1:0];
		it.entry_value = val[DATA_W-1:0];
		it.search_key  = $urandom;
		gen_table[idx] = val;
		pending_items.push_back(it);
	endtask

	task automatic push_search(input longint key);
		item_t it;
		it.func        = FUNC_SEARCH;
		it.entry_index = $urandom;
		it.entry_value = $urandom;
		it.search_key  = key[DATA_W-1:0];
		pending_items.push_back(it);
	endtask

	// Waits until the block has nothing in flight, then lets a write item settle.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Loads entries 0..n-1 with values of the given shape.
	task automatic fill_table(input int n, input table_kind_t kind);
		longint vals[$];
		longint base;
		int     spread, i;
		base   = longint'($urandom_range(0, 32'hFFFF_F000)) + VALUE_MIN;
		spread = $urandom_range(0, 3 * n);
		for (i = 0; i < n; i++) begin
			case (kind)
				TABLE_CLUSTERED: vals.push_back(base + $urandom_range(0, spread));
				TABLE_FLAT:      vals.push_back(base);
				default:         vals.push_back(longint'($urandom) + VALUE_MIN);
			endcase
		end
		if (kind != TABLE_SHUFFLED)
			vals.sort();
		if (kind == TABLE_SPREAD && n >= 2 && $urandom_range(0, 3) == 0) begin
			vals[0]     = VALUE_MIN;
			vals[n - 1] = VALUE_MAX;
		end
		if ($urandom_range(0, 1)) begin
			for (i = 0; i < n; i++)
				push_write(i, vals[i]);
		end else begin
			for (i = n - 1; i >= 0; i--)
				push_write(i, vals[i]);
		end
	endtask

	// Mostly keys that are in the table or just beside one, plus wide random and extremes.
	function automatic longint pick_key(input int n);
		int sel;
		sel = $urandom_range(0, 99);
		if (n > 0 && sel < 55)
			return gen_table[$urandom_range(0, n - 1)];
		if (n > 0 && sel < 75)
			return gen_table[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
		if (sel < 92)
			return longint'($urandom) + VALUE_MIN;
		return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
	endfunction

	// A table write amid searches: order-keeping, out of range, or noise (or, if n is 0, at times a search).
	task automatic push_update(input int n);
		int     sel, i;
		longint lo, hi;
		sel = $urandom_range(0, 99);
		if (n > 0 && sel < 50) begin
			i  = $urandom_range(0, n - 1);
			lo = (i > 0) ? gen_table[i - 1] : VALUE_MIN;
			hi = (i < n - 1) ? gen_table[i + 1] : VALUE_MAX;
			if (hi < lo)
				push_write(i, gen_table[i]);
			else
				push_write(i, lo + longint'($urandom) % (hi - lo + 1));
		end else if (sel < 80 && n < TABLE_DEPTH) begin
			push_write($urandom_range(n, TABLE_DEPTH - 1), longint'($urandom) + VALUE_MIN);
		end else if (n > 0) begin
			push_write($urandom_range(0, n - 1), longint'($urandom) + VALUE_MIN);
		end else begin
			push_search(pick_key(n));
		end
	endtask

	initial begin : stimulus
		int          random_items, n, m, k;
		table_kind_t kind;
		random_items = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table in both modes.
		write_reg(REG_ENTRY_COUNT, 0);
		push_search(VALUE_MIN);
		push_search(VALUE_MAX);
		wait_idle();
		write_reg(REG_SEARCH_MODE, MODE_INTERP);
		push_search(0);
		wait_idle();

		// Small sorted table with both value extremes and a duplicate pair.
		write_reg(REG_ENTRY_COUNT, 8);
		write_reg(REG_SEARCH_MODE, {10'h3FF, MODE_BINARY});
		push_write(0, VALUE_MIN);
		push_write(1, -1000);
		push_write(2, -5);
		push_write(3, 0);
		push_write(4, 7);
		push_write(5, 7);
		push_write(6, 100);
		push_write(7, VALUE_MAX);
		push_search(VALUE_MIN);
		push_search(VALUE_MAX);
		push_search(7);
		push_search(-6);
		push_search(50);
		wait_idle();
		write_reg(REG_SEARCH_MODE, {10'h2AA, MODE_INTERP});
		push_search(VALUE_MIN);
		push_search(VALUE_MAX);
		push_search(7);
		push_search(101);
		wait_idle();

		// Key above the range, then a flat range.
		write_reg(REG_ENTRY_COUNT, 3);
		push_search(0);
		push_write(0, 42);
		push_write(1, 42);
		push_write(2, 42);
		push_search(42);
		push_search(41);
		push_search(43);
		wait_idle();

		// Full table: count above depth saturates, then exactly the depth.
		write_reg(REG_ENTRY_COUNT, 2047);
		write_reg(REG_SEARCH_MODE, MODE_BINARY);
		fill_table(TABLE_DEPTH, TABLE_SPREAD);
		repeat (24) push_search(pick_key(TABLE_DEPTH));
		wait_idle();
		write_reg(REG_SEARCH_MODE, MODE_INTERP);
		repeat (24) push_search(pick_key(TABLE_DEPTH));
		wait_idle();
		write_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
		repeat (12) push_search(pick_key(TABLE_DEPTH));

		// Random phases: fresh table, random mode, then a mixed stream of items.
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			k = $urandom_range(0, 19);
			if (k == 0)
				n = 0;
			else if (k == 1)
				n = $urandom_range(100, 200);
			else
				n = $urandom_range(1, 40);
			kind = table_kind_t'($urandom_range(0, 2));
			if (n <= 16 && $urandom_range(0, 9) == 0)
				kind = TABLE_SHUFFLED;
			write_reg(REG_SEARCH_MODE, $urandom_range(0, 2047));
			write_reg(REG_ENTRY_COUNT, n);
			fill_table(n, kind);
			random_items += n;
			m = $urandom_range(10, 50);
			repeat (m) begin
				if ($urandom_range(0, 99) < 85)
					push_search(pick_key(n));
				else
					push_update(n);
				random_items++;
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit.
	initial begin
		#(TIMEOUT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sts_pkg.sv
rtl/sts_ram.sv
rtl/sorted_table_search.sv
tb/tb_sorted_table_search.sv
